[rtl/bta_pkg.sv]
// Shared types, field widths and codes for the buddy tree allocator.
`default_nettype none

package bta_pkg;

  // Default number of allocation units covered by the tree
  localparam int unsigned DEF_LEAF_COUNT = 1024;

  // Field widths on the stream ports
  localparam int unsigned REQ_W       = 16;
  localparam int unsigned SIZE_W      = 17;   // request size after zero fix-up, holds 65536
  localparam int unsigned ADDR_FW     = 10;
  localparam int unsigned GSIZE_FW    = 11;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  // Request kinds carried on in_tuser
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NO_FREE   = 2'd1,
    STATUS_TOO_LARGE = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEVEL,
    ST_SCAN,
    ST_MARK,
    ST_ANC,
    ST_RESULT
  } bta_state_t;

endpackage

`default_nettype wire

[rtl/bta_node_ram.sv]
// Single-bit node memory: one write port, one registered read port.
`default_nettype none

module bta_node_ram #(
  parameter int unsigned DEPTH  = 2047,
  parameter int unsigned ADDR_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_data
);

  logic mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/buddy_tree_allocator.sv]
// Top level of the buddy tree allocator: sequencer, tree walk and result register.
`default_nettype none

// Binary buddy allocator over a tree of used-bits held in a single-port-write,
// registered-read memory of 2*LEAF_COUNT-1 bits (node 0 is the root, children
// of n are 2n+1 and 2n+2). After reset the sequencer sweeps the memory one
// node per cycle, so no request is taken until the sweep reaches the last node.
// A clear request runs the same sweep and then hands a done result on. An
// oversize request goes straight to the result with status too large.
// An allocate request runs through these steps in order. The request is
// accepted. The block is halved (at most log2 LEAF_COUNT times) while half
// still holds the request, and the level search is left. The nodes of that
// level are read (one read a cycle, up to 2*LEAF_COUNT/size) until a free one
// is found, and the last read is checked. The nodes of the granted subtree
// are written, then its ancestors up to the root. The result register is
// loaded. The walk never reads and writes the memory in the same cycle.
// A request with no free node ends the scan with status no free. A result
// that finds the previous one still waiting for out_tready is held until that
// one is taken. The memory ports set the pace. The longest requests are a
// whole-tree grant and a clear, which each write every node. One request is
// in work at a time. The result register lets a new request enter while the
// previous result waits for out_tready.
module buddy_tree_allocator #(
  parameter int unsigned LEAF_COUNT = bta_pkg::DEF_LEAF_COUNT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bta_pkg::IN_TDATA_W-1:0]      in_tdata,   // [15:0] req_size
  input  logic                                in_tuser,   // [0] kind
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bta_pkg::OUT_TDATA_W-1:0]     out_tdata   // [9:0] block_addr,
                                                          // [20:10] granted_size,
                                                          // [22:21] status, [23] zero
);

  import bta_pkg::*;

  localparam int unsigned NODE_COUNT = 2 * LEAF_COUNT - 1;
  localparam int unsigned NIDX_W     = $clog2(NODE_COUNT);
  localparam int unsigned NCNT_W     = NIDX_W + 3;
  localparam int unsigned BLK_W      = $clog2(LEAF_COUNT + 1);
  localparam int unsigned ADDR_W     = BLK_W + 1;

  localparam logic [NCNT_W-1:0] NC_V      = NCNT_W'(NODE_COUNT);
  localparam logic [NIDX_W-1:0] NIDX_LAST = NIDX_W'(NODE_COUNT - 1);
  localparam logic [SIZE_W-1:0] LEAF_V    = SIZE_W'(LEAF_COUNT);
  localparam logic [BLK_W-1:0]  BLK_INIT  = BLK_W'(LEAF_COUNT);

  bta_state_t state_r, state_nxt;

  logic [SIZE_W-1:0]      size_r, size_nxt;
  logic [BLK_W-1:0]       blk_r, blk_nxt;
  logic [NCNT_W-1:0]      first_r, first_nxt;
  logic [NCNT_W-1:0]      iss_node_r, iss_node_nxt;
  logic [ADDR_W-1:0]      iss_addr_r, iss_addr_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [NIDX_W-1:0]      pend_node_r, pend_node_nxt;
  logic [ADDR_W-1:0]      pend_addr_r, pend_addr_nxt;
  logic [NIDX_W-1:0]      hit_node_r, hit_node_nxt;
  logic [ADDR_W-1:0]      hit_addr_r, hit_addr_nxt;
  logic [NCNT_W-1:0]      mk_first_r, mk_first_nxt;
  logic [NCNT_W-1:0]      mk_last_r, mk_last_nxt;
  logic [NCNT_W-1:0]      mk_k_r, mk_k_nxt;
  logic [NIDX_W-1:0]      anc_r, anc_nxt;
  logic [NIDX_W-1:0]      clr_r, clr_nxt;
  logic                   clr_req_r, clr_req_nxt;
  logic [ADDR_FW-1:0]     res_addr_r, res_addr_nxt;
  logic [GSIZE_FW-1:0]    res_size_r, res_size_nxt;
  status_t                res_status_r, res_status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // memory ports
  logic              wr_en;
  logic [NIDX_W-1:0] wr_addr;
  logic              wr_data;
  logic              rd_en;
  logic              rd_data;

  // shared conditions
  logic [SIZE_W-1:0] req_size_eff;
  logic              req_too_large;
  logic [SIZE_W-1:0] blk_half;
  logic              blk_half_fits;
  logic              can_issue;
  logic              hit;
  logic [NCNT_W-1:0] mk_k_inc;
  logic              mk_row_more;
  logic [NCNT_W-1:0] mk_first_next;
  logic [NCNT_W-1:0] mk_last_next;
  logic              mk_done;
  logic              clr_last;
  logic              out_free;
  logic [NIDX_W-1:0] anc_up;
  logic [31:0]       hit_addr_ext;
  logic [31:0]       blk_ext;

  assign req_size_eff  = (in_tdata[REQ_W-1:0] == '0) ? SIZE_W'(1)
                                                      : SIZE_W'(in_tdata[REQ_W-1:0]);
  assign req_too_large = req_size_eff > LEAF_V;
  assign blk_half      = SIZE_W'(blk_r >> 1);
  assign blk_half_fits = blk_half >= size_r;
  assign can_issue     = (iss_node_r <= (first_r << 1)) && (iss_node_r < NC_V);
  assign hit           = pend_v_r && !rd_data;
  assign mk_k_inc      = mk_k_r + NCNT_W'(1);
  assign mk_row_more   = (mk_k_r < mk_last_r) && (mk_k_inc < NC_V);
  assign mk_first_next = (mk_first_r << 1) + NCNT_W'(1);
  assign mk_last_next  = (mk_last_r << 1) + NCNT_W'(2);
  assign mk_done       = !mk_row_more && (mk_first_next >= NC_V);
  assign clr_last      = clr_r == NIDX_LAST;
  assign out_free      = !out_valid_r || out_tready;
  assign anc_up        = (anc_r - NIDX_W'(1)) >> 1;
  assign hit_addr_ext  = 32'(hit_addr_r);
  assign blk_ext       = 32'(blk_r);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_req_r ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == KIND_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (req_too_large) begin
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_LEVEL;
          end
        end
      end
      ST_LEVEL: begin
        if (!blk_half_fits) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_MARK;
        end else if (!can_issue) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_MARK: begin
        if (mk_done) begin
          state_nxt = ST_ANC;
        end
      end
      ST_ANC: begin
        if (anc_r == '0) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    size_nxt       = size_r;
    blk_nxt        = blk_r;
    first_nxt      = first_r;
    iss_node_nxt   = iss_node_r;
    iss_addr_nxt   = iss_addr_r;
    pend_v_nxt     = pend_v_r;
    pend_node_nxt  = pend_node_r;
    pend_addr_nxt  = pend_addr_r;
    hit_node_nxt   = hit_node_r;
    hit_addr_nxt   = hit_addr_r;
    mk_first_nxt   = mk_first_r;
    mk_last_nxt    = mk_last_r;
    mk_k_nxt       = mk_k_r;
    anc_nxt        = anc_r;
    clr_nxt        = clr_r;
    clr_req_nxt    = clr_req_r;
    res_addr_nxt   = res_addr_r;
    res_size_nxt   = res_size_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    wr_en          = 1'b0;
    wr_addr        = mk_k_r[NIDX_W-1:0];
    wr_data        = 1'b1;
    rd_en          = 1'b0;

    unique case (state_r)
      // sweep the tree to all clear
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = 1'b0;
        clr_nxt = clr_r + NIDX_W'(1);
        if (clr_last) begin
          res_addr_nxt   = '0;
          res_size_nxt   = '0;
          res_status_nxt = STATUS_DONE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == KIND_CLEAR) begin
            clr_nxt     = '0;
            clr_req_nxt = 1'b1;
          end else begin
            size_nxt       = req_size_eff;
            blk_nxt        = BLK_INIT;
            first_nxt      = '0;
            res_addr_nxt   = '0;
            res_size_nxt   = '0;
            res_status_nxt = STATUS_TOO_LARGE;
          end
        end
      end
      // halve the block while half still holds the request
      ST_LEVEL: begin
        if (blk_half_fits) begin
          blk_nxt   = blk_r >> 1;
          first_nxt = (first_r << 1) + NCNT_W'(1);
        end else begin
          iss_node_nxt = first_r;
          iss_addr_nxt = '0;
          pend_v_nxt   = 1'b0;
        end
      end
      // one read issued per cycle until a hit, previous read checked
      ST_SCAN: begin
        if (hit) begin
          hit_node_nxt = pend_node_r;
          hit_addr_nxt = pend_addr_r;
          mk_first_nxt = NCNT_W'(pend_node_r);
          mk_last_nxt  = NCNT_W'(pend_node_r);
          mk_k_nxt     = NCNT_W'(pend_node_r);
          pend_v_nxt   = 1'b0;
        end else if (can_issue) begin
          rd_en         = 1'b1;
          pend_v_nxt    = 1'b1;
          pend_node_nxt = iss_node_r[NIDX_W-1:0];
          pend_addr_nxt = iss_addr_r;
          iss_node_nxt  = iss_node_r + NCNT_W'(1);
          iss_addr_nxt  = iss_addr_r + ADDR_W'(blk_r);
        end else begin
          pend_v_nxt     = 1'b0;
          res_addr_nxt   = '0;
          res_size_nxt   = '0;
          res_status_nxt = STATUS_NO_FREE;
        end
      end
      // mark the granted subtree, row by row
      ST_MARK: begin
        wr_en = 1'b1;
        if (mk_row_more) begin
          mk_k_nxt = mk_k_inc;
        end else begin
          mk_first_nxt = mk_first_next;
          mk_last_nxt  = mk_last_next;
          mk_k_nxt     = mk_first_next;
          anc_nxt      = hit_node_r;
        end
      end
      // mark ancestors up to the root
      ST_ANC: begin
        if (anc_r != '0) begin
          wr_en   = 1'b1;
          wr_addr = anc_up;
          anc_nxt = anc_up;
        end else begin
          res_addr_nxt   = hit_addr_ext[ADDR_FW-1:0];
          res_size_nxt   = blk_ext[GSIZE_FW-1:0];
          res_status_nxt = STATUS_DONE;
        end
      end
      // hand the result to the output register
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, res_status_r, res_size_r, res_addr_r};
          clr_req_nxt   = 1'b0;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      clr_req_r   <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_req_r   <= clr_req_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    blk_r        <= blk_nxt;
    first_r      <= first_nxt;
    iss_node_r   <= iss_node_nxt;
    iss_addr_r   <= iss_addr_nxt;
    pend_node_r  <= pend_node_nxt;
    pend_addr_r  <= pend_addr_nxt;
    hit_node_r   <= hit_node_nxt;
    hit_addr_r   <= hit_addr_nxt;
    mk_first_r   <= mk_first_nxt;
    mk_last_r    <= mk_last_nxt;
    mk_k_r       <= mk_k_nxt;
    anc_r        <= anc_nxt;
    res_addr_r   <= res_addr_nxt;
    res_size_r   <= res_size_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Used-bit memory
  bta_node_ram #(
    .DEPTH  (NODE_COUNT),
    .ADDR_W (NIDX_W)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (iss_node_r[NIDX_W-1:0]),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
